/* hw/rtl/axbs_pkg.sv */
// Package with shared widths, constants, types and helpers of the burst splitter.
package axbs_pkg;

   // Bus and request limits.
   localparam int BUS_BYTES  = 16;
   localparam int MAX_LENGTH = 4096;

   // Field widths of the request and response transfers.
   localparam int ADDR_W   = 64;
   localparam int LEN_W    = 17;
   localparam int OFFS_W   = 12;
   localparam int BEAT_W   = 5;
   localparam int COUNT_W  = 9;
   localparam int SIZE_W   = 3;

   // Internal widths: byte counts within one request and the 4 KB page.
   localparam int LEFT_W   = 13;
   localparam int PAGE_W   = 12;
   localparam int BYTES_W  = 16;

   // Page size and the largest beat count of one burst.
   localparam logic [LEFT_W-1:0] PAGE_BYTES = LEFT_W'(4096);
   localparam logic [LEFT_W-1:0] MAX_BEATS  = LEFT_W'(256);

   // Log2 of the widest power-of-two beat that fits the bus.
   function automatic int top_size_f();
      int beat;
      int size;
      beat = 1;
      size = 0;
      while ((beat * 2 <= BUS_BYTES) && (size < 7)) begin
         beat = beat * 2;
         size = size + 1;
      end
      return size;
   endfunction

   localparam int TOP_SIZE = top_size_f();

   // One burst as computed by the step unit, with the state it leaves behind.
   typedef struct packed {
      logic [ADDR_W-1:0]  burst_address;
      logic [OFFS_W-1:0]  byte_offset;
      logic [BEAT_W-1:0]  beat_bytes;
      logic [COUNT_W-1:0] beat_count;
      logic [SIZE_W-1:0]  size_code;
      logic               is_last;
      logic [ADDR_W-1:0]  next_address;
      logic [LEFT_W-1:0]  next_offset;
      logic [LEFT_W-1:0]  bytes_left;
   } burst_type;

endpackage

/* hw/rtl/axbs_if.sv */
// Valid/ready channel interfaces for requests and bursts.
interface axbs_req_if;
   logic                            valid;
   logic                            ready;
   logic [axbs_pkg::ADDR_W-1:0]     start_address;
   logic [axbs_pkg::LEN_W-1:0]      request_length;

   modport source (output valid, output start_address, output request_length, input ready);
   modport sink   (input valid, input start_address, input request_length, output ready);
endinterface

interface axbs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [axbs_pkg::ADDR_W-1:0]     burst_address;
   logic [axbs_pkg::OFFS_W-1:0]     byte_offset;
   logic [axbs_pkg::BEAT_W-1:0]     beat_bytes;
   logic [axbs_pkg::COUNT_W-1:0]    beat_count;
   logic [axbs_pkg::SIZE_W-1:0]     size_code;
   logic                            is_last;
   logic                            error;

   modport source (output valid, output burst_address, output byte_offset,
                   output beat_bytes, output beat_count, output size_code,
                   output is_last, output error, input ready);
   modport sink   (input valid, input burst_address, input byte_offset,
                   input beat_bytes, input beat_count, input size_code,
                   input is_last, input error, output ready);
endinterface

/* hw/rtl/axbs_step.sv */
// Burst step unit: sizes one burst from the current address and bytes left.
module axbs_step (
   input  logic [axbs_pkg::ADDR_W-1:0]  cur_address,
   input  logic [axbs_pkg::LEFT_W-1:0]  cur_offset,
   input  logic [axbs_pkg::LEFT_W-1:0]  cur_left,
   output axbs_pkg::burst_type          burst
);

   logic [axbs_pkg::SIZE_W-1:0]  size;
   logic [axbs_pkg::LEFT_W-1:0]  by_length;
   logic [axbs_pkg::LEFT_W-1:0]  to_edge;
   logic [axbs_pkg::LEFT_W-1:0]  beats;
   logic [axbs_pkg::BYTES_W-1:0] bytes;
   logic [axbs_pkg::LEFT_W-1:0]  bytes_short;
   logic [7:0]                   beat_wide;

   // Widest beat that fits the bytes left and divides the address. The fit
   // conditions are monotonic, so the last size that fits is the widest.
   always_comb begin
      size = '0;
      for (int s = 1; s <= axbs_pkg::TOP_SIZE; s++) begin
         if ((cur_left >= (axbs_pkg::LEFT_W'(1) << s)) &&
             ((cur_address & ((axbs_pkg::ADDR_W'(1) << s) - axbs_pkg::ADDR_W'(1))) == '0)) begin
            size = axbs_pkg::SIZE_W'(s);
         end
      end
   end

   // Beat count is the smallest of the length limit, the burst limit and
   // the beats left before the next 4 KB boundary.
   always_comb begin
      by_length = cur_left >> size;
      to_edge   = (axbs_pkg::PAGE_BYTES - {1'b0, cur_address[axbs_pkg::PAGE_W-1:0]}) >> size;
      beats     = by_length;
      if (beats > axbs_pkg::MAX_BEATS) begin
         beats = axbs_pkg::MAX_BEATS;
      end
      if (beats > to_edge) begin
         beats = to_edge;
      end
      bytes       = axbs_pkg::BYTES_W'(beats) << size;
      bytes_short = bytes[axbs_pkg::LEFT_W-1:0];
      beat_wide   = 8'(1) << size;
   end

   // Burst fields and the state that the next step starts from.
   always_comb begin
      burst.burst_address = cur_address;
      burst.byte_offset   = cur_offset[axbs_pkg::OFFS_W-1:0];
      burst.beat_bytes    = beat_wide[axbs_pkg::BEAT_W-1:0];
      burst.beat_count    = beats[axbs_pkg::COUNT_W-1:0];
      burst.size_code     = size;
      burst.is_last       = (bytes_short == cur_left);
      burst.next_address  = cur_address + axbs_pkg::ADDR_W'(bytes);
      burst.next_offset   = cur_offset + bytes_short;
      burst.bytes_left    = cur_left - bytes_short;
   end

endmodule

/* hw/rtl/axi_burst_splitter.sv */
// Top level of the AXI INCR burst splitter.
//
// A request transfer (start address, byte length) is split into AXI INCR
// bursts that never cross a 4 KB boundary, each using the widest beat that
// fits the bytes left and the address alignment, with at most 256 beats. A
// request of zero length, of more than MAX_LENGTH bytes, or whose start
// address plus length overflows 64 bits yields one response with error
// set and all other fields zero. A single step unit sizes one burst per
// cycle while the response register is empty or being taken; the request
// side is ready only while no request is being split. The response
// register lets the next request be taken while the final burst still
// waits to be taken.
module axi_burst_splitter (
   input  logic      clock,
   input  logic      reset,
   axbs_req_if.sink  req_chan,
   axbs_rsp_if.source rsp_chan
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                            state_ff, state_in;
   logic [axbs_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [axbs_pkg::LEFT_W-1:0]     offset_ff, offset_in;
   logic [axbs_pkg::LEFT_W-1:0]     left_ff, left_in;
   logic                            err_ff, err_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [axbs_pkg::ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [axbs_pkg::OFFS_W-1:0]     rsp_offs_ff, rsp_offs_in;
   logic [axbs_pkg::BEAT_W-1:0]     rsp_beat_ff, rsp_beat_in;
   logic [axbs_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [axbs_pkg::SIZE_W-1:0]     rsp_size_ff, rsp_size_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            rsp_err_ff, rsp_err_in;

   logic                            req_take;
   logic                            slot_free;
   logic                            emit;
   logic [axbs_pkg::ADDR_W:0]       end_sum;
   logic                            bad_request;
   axbs_pkg::burst_type             burst;

   // Single burst step unit.
   axbs_step u_step (
      .cur_address (addr_ff),
      .cur_offset  (offset_ff),
      .cur_left    (left_ff),
      .burst       (burst)
   );

   // Handshakes and request checks.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign emit           = (state_ff == ST_RUN) && slot_free;
   assign end_sum        = {1'b0, req_chan.start_address} +
                           (axbs_pkg::ADDR_W + 1)'(req_chan.request_length);
   assign bad_request    = (req_chan.request_length == '0) ||
                           (req_chan.request_length > axbs_pkg::LEN_W'(axbs_pkg::MAX_LENGTH)) ||
                           end_sum[axbs_pkg::ADDR_W];

   // Sequencer: load a request, then emit one burst, or one error response, per free response slot.
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      offset_in    = offset_ff;
      left_in      = left_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_offs_in  = rsp_offs_ff;
      rsp_beat_in  = rsp_beat_ff;
      rsp_count_in = rsp_count_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      if (req_take) begin
         state_in  = ST_RUN;
         addr_in   = req_chan.start_address;
         offset_in = '0;
         left_in   = req_chan.request_length[axbs_pkg::LEFT_W-1:0];
         err_in    = bad_request;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            rsp_addr_in  = '0;
            rsp_offs_in  = '0;
            rsp_beat_in  = '0;
            rsp_count_in = '0;
            rsp_size_in  = '0;
            rsp_last_in  = 1'b0;
            rsp_err_in   = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            rsp_addr_in  = burst.burst_address;
            rsp_offs_in  = burst.byte_offset;
            rsp_beat_in  = burst.beat_bytes;
            rsp_count_in = burst.beat_count;
            rsp_size_in  = burst.size_code;
            rsp_last_in  = burst.is_last;
            rsp_err_in   = 1'b0;
            addr_in      = burst.next_address;
            offset_in    = burst.next_offset;
            left_in      = burst.bytes_left;
            if (burst.is_last) begin
               state_in = ST_IDLE;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working state and response payload.
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      offset_ff    <= offset_in;
      left_ff      <= left_in;
      err_ff       <= err_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_offs_ff  <= rsp_offs_in;
      rsp_beat_ff  <= rsp_beat_in;
      rsp_count_ff <= rsp_count_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // Response outputs.
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.burst_address = rsp_addr_ff;
   assign rsp_chan.byte_offset   = rsp_offs_ff;
   assign rsp_chan.beat_bytes    = rsp_beat_ff;
   assign rsp_chan.beat_count    = rsp_count_ff;
   assign rsp_chan.size_code     = rsp_size_ff;
   assign rsp_chan.is_last       = rsp_last_ff;
   assign rsp_chan.error         = rsp_err_ff;

endmodule

/* hw/rtl/axbs_checker.sv */
// Port checker of the burst splitter and its bind to the top level.
module axbs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [axbs_pkg::ADDR_W-1:0]     rsp_burst_address,
   input logic [axbs_pkg::BEAT_W-1:0]     rsp_beat_bytes,
   input logic [axbs_pkg::COUNT_W-1:0]    rsp_beat_count,
   input logic [axbs_pkg::SIZE_W-1:0]     rsp_size_code,
   input logic                            rsp_is_last,
   input logic                            rsp_error
);

   // An error response has zero address, zero beat count and is_last clear.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |->
         (rsp_burst_address == '0) && (rsp_beat_count == '0) && !rsp_is_last)
      else $error("error response with nonzero fields");

   // A burst has at least one beat and its beat width matches its size code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_error) |->
         (rsp_beat_count != '0) &&
         (rsp_beat_bytes == axbs_pkg::BEAT_W'(8'(1) << rsp_size_code)))
      else $error("burst with bad beat count or size");

   // Once a request is taken, the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while splitting");

   // A stalled response stays valid and holds its address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_burst_address))
      else $error("stalled response changed");

endmodule

bind axi_burst_splitter axbs_checker u_axbs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_burst_address (rsp_chan.burst_address),
   .rsp_beat_bytes    (rsp_chan.beat_bytes),
   .rsp_beat_count    (rsp_chan.beat_count),
   .rsp_size_code     (rsp_chan.size_code),
   .rsp_is_last       (rsp_chan.is_last),
   .rsp_error         (rsp_chan.error)
);
